FILE: design/segip_pkg.sv
// Package: shared constants for the segment crossing point pipeline.
`default_nettype none
package segip_pkg;
  localparam int IN_BITS         = 16;
  localparam int OUT_BITS        = 24;
  localparam int COORD_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 8;
endpackage
`default_nettype wire

FILE: design/segment_intersection_point_core.sv
// Top level: pipelined 2D segment crossing test and crossing point in fixed point.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one segment pair per item: A, B of
//   the first segment and C, D of the second, signed integer coordinates.
//   Result channel (out_valid/out_ready) returns one item per input item, in
//   order: out_hit and the crossing point scaled by 2^FRAC_BITS, zero on a miss.
//   Pipeline: six front stages (capture, differences, products, line values,
//   sign test, dividend product), one restoring-divider stage per quotient bit,
//   and the output register. Throughput: one item per cycle while out_ready
//   is high; the divider is fully unrolled in stages.
//   Reset empties every stage; the block then takes an item each cycle.
//   When the receiver stalls, full stages hold and empty stages keep filling
//   until the pipeline is full, then in_ready drops. Nothing is lost or
//   repeated.
//   Touching, collinear, parallel and zero-length cases report no hit.
//   Points outside 24 signed bits saturate.
`default_nettype none
module segment_intersection_point_core #(
  parameter int COORD_BITS = segip_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = segip_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [segip_pkg::IN_BITS-1:0]   in_seg1_start_x,
  input  wire logic signed [segip_pkg::IN_BITS-1:0]   in_seg1_start_y,
  input  wire logic signed [segip_pkg::IN_BITS-1:0]   in_seg1_end_x,
  input  wire logic signed [segip_pkg::IN_BITS-1:0]   in_seg1_end_y,
  input  wire logic signed [segip_pkg::IN_BITS-1:0]   in_seg2_start_x,
  input  wire logic signed [segip_pkg::IN_BITS-1:0]   in_seg2_start_y,
  input  wire logic signed [segip_pkg::IN_BITS-1:0]   in_seg2_end_x,
  input  wire logic signed [segip_pkg::IN_BITS-1:0]   in_seg2_end_y,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        out_hit,
  output logic signed [segip_pkg::OUT_BITS-1:0]       out_cross_x,
  output logic signed [segip_pkg::OUT_BITS-1:0]       out_cross_y
);
  import segip_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int NW   = 2 * CB + 2;
  localparam int DENW = NW + 1;
  localparam int QB   = DW + FRAC_BITS;
  localparam int MPW  = QB + NW;
  localparam int VW   = QB + 2;
  localparam int EW   = (VW > OUT_BITS) ? VW : OUT_BITS;
  localparam int NS   = QB + 7;
  localparam int DIV0 = 5;
  localparam int OST  = NS - 1;

  typedef struct packed {
    logic                 hit;
    logic                 negx;
    logic                 negy;
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic [DENW-1:0]      den;
  } carry_t;

  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[OST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: capture coordinates
  logic [IN_BITS-1:0]   raw [8];
  logic signed [CB-1:0] c0_r [8];

  assign raw[0] = in_seg1_start_x;
  assign raw[1] = in_seg1_start_y;
  assign raw[2] = in_seg1_end_x;
  assign raw[3] = in_seg1_end_y;
  assign raw[4] = in_seg2_start_x;
  assign raw[5] = in_seg2_start_y;
  assign raw[6] = in_seg2_end_x;
  assign raw[7] = in_seg2_end_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 8; i++) begin
        c0_r[i] <= CB'({{CB{1'b0}}, raw[i]});
      end
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] e1 [8];
  logic signed [DW-1:0] d1x_r, d1y_r, d2x_r, d2y_r;
  logic signed [DW-1:0] acy_r, acx_r, bcy_r, bcx_r, cay_r, cax_r, day_r, dax_r;
  logic signed [CB-1:0] ax1_r, ay1_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      e1[i] = DW'(c0_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1x_r <= e1[2] - e1[0];
      d1y_r <= e1[3] - e1[1];
      d2x_r <= e1[6] - e1[4];
      d2y_r <= e1[7] - e1[5];
      acy_r <= e1[1] - e1[5];
      acx_r <= e1[0] - e1[4];
      bcy_r <= e1[3] - e1[5];
      bcx_r <= e1[2] - e1[4];
      cay_r <= e1[5] - e1[1];
      cax_r <= e1[4] - e1[0];
      day_r <= e1[7] - e1[1];
      dax_r <= e1[6] - e1[0];
      ax1_r <= c0_r[0];
      ay1_r <= c0_r[1];
    end
  end

  // stage 2: products
  logic signed [PW-1:0] s1a_r, s1b_r, s2a_r, s2b_r, t1a_r, t1b_r, t2a_r, t2b_r;
  logic signed [DW-1:0] d1x2_r, d1y2_r;
  logic signed [CB-1:0] ax2_r, ay2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s1a_r  <= PW'(d2x_r) * PW'(acy_r);
      s1b_r  <= PW'(d2y_r) * PW'(acx_r);
      s2a_r  <= PW'(d2x_r) * PW'(bcy_r);
      s2b_r  <= PW'(d2y_r) * PW'(bcx_r);
      t1a_r  <= PW'(d1x_r) * PW'(cay_r);
      t1b_r  <= PW'(d1y_r) * PW'(cax_r);
      t2a_r  <= PW'(d1x_r) * PW'(day_r);
      t2b_r  <= PW'(d1y_r) * PW'(dax_r);
      d1x2_r <= d1x_r;
      d1y2_r <= d1y_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
    end
  end

  // stage 3: line values
  logic signed [SW-1:0] s1_r, s2_r, t1_r, t2_r;
  logic signed [DW-1:0] d1x3_r, d1y3_r;
  logic signed [CB-1:0] ax3_r, ay3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s1_r   <= SW'(s1a_r) - SW'(s1b_r);
      s2_r   <= SW'(s2a_r) - SW'(s2b_r);
      t1_r   <= SW'(t1a_r) - SW'(t1b_r);
      t2_r   <= SW'(t2a_r) - SW'(t2b_r);
      d1x3_r <= d1x2_r;
      d1y3_r <= d1y2_r;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
    end
  end

  // stage 4: sign test, magnitudes
  logic            s_cross, t_cross;
  logic [SW-1:0]   s1m, s2m, dxm, dym;
  logic [NW-1:0]   num4_r;
  logic [DW-1:0]   magx4_r, magy4_r;
  carry_t          cy4_r;

  always_comb begin
    s_cross = (s1_r < 0 && s2_r > 0) || (s1_r > 0 && s2_r < 0);
    t_cross = (t1_r < 0 && t2_r > 0) || (t1_r > 0 && t2_r < 0);
    s1m     = s1_r[SW-1] ? SW'(-s1_r) : SW'(s1_r);
    s2m     = s2_r[SW-1] ? SW'(-s2_r) : SW'(s2_r);
    dxm     = d1x3_r[DW-1] ? SW'(-SW'(d1x3_r)) : SW'(d1x3_r);
    dym     = d1y3_r[DW-1] ? SW'(-SW'(d1y3_r)) : SW'(d1y3_r);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      num4_r     <= NW'(s1m);
      magx4_r    <= DW'(dxm);
      magy4_r    <= DW'(dym);
      cy4_r.hit  <= s_cross && t_cross;
      cy4_r.negx <= d1x3_r[DW-1];
      cy4_r.negy <= d1y3_r[DW-1];
      cy4_r.ax   <= ax3_r;
      cy4_r.ay   <= ay3_r;
      cy4_r.den  <= DENW'(s1m) + DENW'(s2m);
    end
  end

  // stage 5 onward: dividend product, then one quotient bit per stage
  logic [DENW-1:0] rem_r [2][QB+1];
  logic [QB-1:0]   qn_r  [2][QB+1];
  carry_t          cy_r  [QB+1];
  logic [QB-1:0]   mx, my;
  logic [MPW-1:0]  px, py;

  always_comb begin
    mx = QB'(magx4_r) << FRAC_BITS;
    my = QB'(magy4_r) << FRAC_BITS;
    px = MPW'(mx) * MPW'(num4_r);
    py = MPW'(my) * MPW'(num4_r);
  end

  always_ff @(posedge clk) begin
    if (en[DIV0]) begin
      rem_r[0][0] <= DENW'(px[MPW-1:QB]);
      rem_r[1][0] <= DENW'(py[MPW-1:QB]);
      qn_r[0][0]  <= px[QB-1:0];
      qn_r[1][0]  <= py[QB-1:0];
      cy_r[0]     <= cy4_r;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [DENW:0]   tr   [2];
    logic [DENW-1:0] rnxt [2];
    logic            qb   [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        tr[l] = {rem_r[l][j], qn_r[l][j][QB-1]};
        qb[l] = tr[l] >= (DENW+1)'(cy_r[j].den);
        rnxt[l] = qb[l] ? DENW'(tr[l] - (DENW+1)'(cy_r[j].den)) : DENW'(tr[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (en[DIV0+1+j]) begin
        rem_r[0][j+1] <= rnxt[0];
        rem_r[1][j+1] <= rnxt[1];
        qn_r[0][j+1]  <= {qn_r[0][j][QB-2:0], qb[0]};
        qn_r[1][j+1]  <= {qn_r[1][j][QB-2:0], qb[1]};
        cy_r[j+1]     <= cy_r[j];
      end
    end
  end

  // output stage: add offset to base, saturate, zero the point on a miss
  localparam logic signed [EW-1:0] SMAX = EW'((64'sd1 <<< (OUT_BITS - 1)) - 1);
  localparam logic signed [EW-1:0] SMIN = EW'(-(64'sd1 <<< (OUT_BITS - 1)));

  carry_t                 cf;
  logic signed [VW-1:0]   bx, by, vx, vy;
  logic signed [EW-1:0]   wx, wy;
  logic signed [OUT_BITS-1:0] ox, oy;

  always_comb begin
    cf = cy_r[QB];
    bx = VW'(cf.ax) <<< FRAC_BITS;
    by = VW'(cf.ay) <<< FRAC_BITS;
    vx = cf.negx ? bx - VW'({1'b0, qn_r[0][QB]}) : bx + VW'({1'b0, qn_r[0][QB]});
    vy = cf.negy ? by - VW'({1'b0, qn_r[1][QB]}) : by + VW'({1'b0, qn_r[1][QB]});
    wx = EW'(vx);
    wy = EW'(vy);
    if (wx > SMAX) begin
      ox = OUT_BITS'(SMAX);
    end else if (wx < SMIN) begin
      ox = OUT_BITS'(SMIN);
    end else begin
      ox = OUT_BITS'(wx);
    end
    if (wy > SMAX) begin
      oy = OUT_BITS'(SMAX);
    end else if (wy < SMIN) begin
      oy = OUT_BITS'(SMIN);
    end else begin
      oy = OUT_BITS'(wy);
    end
  end

  always_ff @(posedge clk) begin
    if (en[OST]) begin
      out_hit     <= cf.hit;
      out_cross_x <= cf.hit ? ox : '0;
      out_cross_y <= cf.hit ? oy : '0;
    end
  end
endmodule
`default_nettype wire

FILE: design/segip_checker.sv
// Checker: port-level properties of the segment crossing core, with its bind.
`default_nettype none
module segip_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic                                out_hit,
  input wire logic signed [segip_pkg::OUT_BITS-1:0] out_cross_x,
  input wire logic signed [segip_pkg::OUT_BITS-1:0] out_cross_y
);
  import segip_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit)
      && $stable(out_cross_x) && $stable(out_cross_y))
    else $error("stalled item changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_cross_x == '0 && out_cross_y == '0)
    else $error("point not zero on miss");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("item out after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
endmodule

bind segment_intersection_point_core segip_checker u_segip_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_hit     (out_hit),
  .out_cross_x (out_cross_x),
  .out_cross_y (out_cross_y)
);
`default_nettype wire
